// ===== src/phsv_pkg.sv =====
// Package for the palette HSV adjust block: widths, constants, codes and types.
// Used by every design module of the block; depends on nothing.
`timescale 1ns / 1ps

package phsv_pkg;

    // Block constants
    localparam int PALETTE_ENTRIES   = 256;
    localparam int HUE_FRACTION_BITS = 8;
    localparam int HF                = HUE_FRACTION_BITS;

    // Hue widths
    localparam int HN_W   = 17 + HF;  // hue dividend magnitude
    localparam int HQ_W   = 9 + HF;   // hue quotient, up to 360 degrees
    localparam int H_W    = 11 + HF;  // shifted hue, signed
    localparam int HMAG_W = 10 + HF;  // magnitude of shifted hue
    localparam int SECT_W = 6 + HF;   // remainder below one sector
    localparam int SECT   = 60 * (2 ** HF);
    localparam int H360   = 360 * (2 ** HF);
    localparam int HONE   = 2 ** HF;

    // Pipelined divider
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (HN_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;

    // Pipeline depth
    localparam int BACK_STAGES = 7;
    localparam int PIPE_DEPTH  = 1 + DIV_STAGES + BACK_STAGES;

    // Saturation and product widths
    localparam int SAT_FRAC   = 12;
    localparam int SAT_ONE    = 4096;
    localparam int SAT_ONE_SQ = 16777216;
    localparam int SAT_SQ_SH  = 24;
    localparam int S_W        = 17;
    localparam int SQ_W       = 13;
    localparam int V_W        = 10;
    localparam int FQ_W       = 12;
    localparam int F_W        = 13;
    localparam int F_HALF     = 6;
    localparam int SF_W       = 30;
    localparam int OMF_W      = 14;
    localparam int ST_W       = 31;
    localparam int QT_W       = 30;
    localparam int QP_W       = 40;
    localparam int PT_W       = 17;
    localparam int PP_W       = 27;
    localparam int C_W        = 16;   // component before clamping

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE = 2'd2;

    // Sector codes
    typedef logic [2:0] t_sector;
    localparam t_sector SEC_0   = 3'd0;
    localparam t_sector SEC_1   = 3'd1;
    localparam t_sector SEC_2   = 3'd2;
    localparam t_sector SEC_3   = 3'd3;
    localparam t_sector SEC_4   = 3'd4;
    localparam t_sector SEC_DEF = 3'd5;

    // Configured offsets
    typedef struct packed {
        logic signed [9:0] hue;
        logic signed [3:0] sat;
        logic signed [8:0] value;
    } t_shifts;

    // Per-item side data from the front stage
    typedef struct packed {
        logic       pass;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] mx;
        logic       hneg;
        logic       black;
        logic       gray;
    } t_front;

endpackage

// ===== src/palette_hsv_adjust_top.sv =====
// Top level of the palette HSV adjust block: handshake, offsets, pipeline.
// Depends on phsv_pkg, phsv_front, phsv_div and phsv_back.
`timescale 1ns / 1ps
//
// Usage:
//  Input channel: i_valid / o_stall with i_entry_index and i_red_in,
//  i_green_in, i_blue_in. An item is taken when i_valid is high and o_stall
//  is low. Output channel: o_valid / i_stall with o_red_out, o_green_out,
//  o_blue_out; one result item per input item, in order.
//  Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index
//  0 hue, 1 saturation, 2 value; index 3 is ignored. Write while idle.
//  Stages: PIPE_DEPTH (1 front + 7 divider + 7 back = 15 at the default
//  hue fraction). Throughput: one item per cycle while not stalled; the
//  hue and saturation dividers retire four quotient bits per stage.
//  Reset clears the offsets to zero and empties the pipeline.
//  When the receiver stalls a valid result, the whole pipeline freezes and
//  o_stall rises; the held result stays on the output until taken.
//

module palette_hsv_adjust_top import phsv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_entry_index,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                  en;
    logic [PIPE_DEPTH-1:0] r_valid;
    t_shifts               r_shifts;
    t_front                front_side;
    logic [HN_W-1:0]       front_hnum, front_snum;
    logic [7:0]            front_delta;
    logic [DIV_W-1:0]      hq_full, sq_full;
    t_front                r_side [DIV_STAGES];

    // Pipeline advances unless a finished item is held at the output
    assign en          = !(r_valid[PIPE_DEPTH-1] && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_valid[PIPE_DEPTH-1];
    assign o_cfg_ready = 1'b1;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], i_valid};
        end
    end

    // Offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifts <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HUE:   r_shifts.hue   <= signed'(i_cfg_data);
                CFG_SAT:   r_shifts.sat   <= signed'(i_cfg_data[3:0]);
                CFG_VALUE: r_shifts.value <= signed'(i_cfg_data[8:0]);
                default:   ;
            endcase
        end
    end

    phsv_front u_front (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_entry_index (i_entry_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_shifts      (r_shifts),
        .o_side        (front_side),
        .o_hnum        (front_hnum),
        .o_snum        (front_snum),
        .o_delta       (front_delta)
    );

    // Hue: numerator over delta
    phsv_div u_div_hue (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_W'(front_hnum)),
        .i_den (front_delta),
        .o_quo (hq_full)
    );

    // Saturation: delta * 4096 over max
    phsv_div u_div_sat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (DIV_W'(front_snum)),
        .i_den (front_side.mx),
        .o_quo (sq_full)
    );

    // Side data delay matching the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= front_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    phsv_back u_back (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_side      (r_side[DIV_STAGES-1]),
        .i_hq        (hq_full[HQ_W-1:0]),
        .i_sq        (sq_full[SQ_W-1:0]),
        .i_shifts    (r_shifts),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out)
    );

endmodule

// ===== src/phsv_front.sv =====
// Front stage: max/min, hue and saturation dividends, bypass decision.
// Depends on phsv_pkg.
`timescale 1ns / 1ps

module phsv_front import phsv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [7:0]       i_entry_index,
    input  logic [7:0]       i_red_in,
    input  logic [7:0]       i_green_in,
    input  logic [7:0]       i_blue_in,
    input  t_shifts          i_shifts,
    output t_front           o_side,
    output logic [HN_W-1:0]  o_hnum,
    output logic [HN_W-1:0]  o_snum,
    output logic [7:0]       o_delta
);

    logic [7:0]         mx, mn, delta;
    logic signed [11:0] rs, gs, bs, ds, n0;
    logic [10:0]        nmag;
    logic [16:0]        n60;
    t_front             n_side;
    logic [HN_W-1:0]    n_hnum, n_snum;

    t_front             r_side;
    logic [HN_W-1:0]    r_hnum, r_snum;
    logic [7:0]         r_delta;

    // Hue numerator over delta, in degrees with HF fraction bits
    always_comb begin
        mx = (i_red_in > i_green_in) ? i_red_in : i_green_in;
        if (i_blue_in > mx) mx = i_blue_in;
        mn = (i_red_in < i_green_in) ? i_red_in : i_green_in;
        if (i_blue_in < mn) mn = i_blue_in;
        delta = mx - mn;

        rs = signed'({4'b0, i_red_in});
        gs = signed'({4'b0, i_green_in});
        bs = signed'({4'b0, i_blue_in});
        ds = signed'({4'b0, delta});
        if (i_red_in == mx) begin
            n0 = gs - bs;
        end else if (i_green_in == mx) begin
            n0 = (ds <<< 1) + bs - rs;
        end else begin
            n0 = (ds <<< 2) + rs - gs;
        end
        nmag   = n0[11] ? 11'(-n0) : n0[10:0];
        n60    = 17'(nmag) * 17'd60;
        n_hnum = HN_W'(n60) << HF;
        n_snum = HN_W'(delta) << SAT_FRAC;

        n_side.pass  = (i_entry_index == 8'd0) ||
                       ({1'b0, i_entry_index} >= 9'(PALETTE_ENTRIES)) ||
                       (i_shifts.hue == 10'sd0 && i_shifts.sat == 4'sd0 &&
                        i_shifts.value == 9'sd0);
        n_side.red   = i_red_in;
        n_side.green = i_green_in;
        n_side.blue  = i_blue_in;
        n_side.mx    = mx;
        n_side.hneg  = n0[11];
        n_side.black = (mx == 8'd0);
        n_side.gray  = (delta == 8'd0);
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= n_side;
            r_hnum  <= n_hnum;
            r_snum  <= n_snum;
            r_delta <= delta;
        end
    end

    assign o_side  = r_side;
    assign o_hnum  = r_hnum;
    assign o_snum  = r_snum;
    assign o_delta = r_delta;

endmodule

// ===== src/phsv_div.sv =====
// Pipelined restoring divider, DIV_STEP quotient bits per stage, 8-bit divisor.
// Depends on phsv_pkg.
`timescale 1ns / 1ps

module phsv_div import phsv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_num,
    input  logic [7:0]       i_den,
    output logic [DIV_W-1:0] o_quo
);

    // acc shifts the dividend out at the top and the quotient in at the bottom
    typedef struct packed {
        logic [7:0]       rem;
        logic [DIV_W-1:0] acc;
        logic [7:0]       den;
    } t_div_lane;

    t_div_lane r_lane [DIV_STAGES];
    t_div_lane n_lane [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        // DIV_STEP compare-subtract steps
        always_comb begin : p_step
            t_div_lane  cur;
            logic [8:0] rem2;
            if (k == 0) begin
                cur.rem = 8'd0;
                cur.acc = i_num;
                cur.den = i_den;
            end else begin
                cur = r_lane[(k == 0) ? 0 : k - 1];
            end
            for (int j = 0; j < DIV_STEP; j++) begin
                rem2    = {cur.rem, cur.acc[DIV_W-1]};
                cur.acc = {cur.acc[DIV_W-2:0], 1'b0};
                if (rem2 >= {1'b0, cur.den}) begin
                    cur.rem    = 8'(rem2 - {1'b0, cur.den});
                    cur.acc[0] = 1'b1;
                end else begin
                    cur.rem = rem2[7:0];
                end
            end
            n_lane[k] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lane[k] <= n_lane[k];
            end
        end
    end

    assign o_quo = r_lane[DIV_STAGES-1].acc;

endmodule

// ===== src/phsv_back.sv =====
// Back end: hue/saturation/value offsets, sector split, products, clamp.
// Seven register stages; depends on phsv_pkg.
`timescale 1ns / 1ps

module phsv_back import phsv_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  t_front          i_side,
    input  logic [HQ_W-1:0] i_hq,
    input  logic [SQ_W-1:0] i_sq,
    input  t_shifts         i_shifts,
    output logic [7:0]      o_red_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_blue_out
);

    typedef struct packed {
        logic [SECT_W-1:0] rem;
        logic [FQ_W-1:0]   fq;
    } t_fdiv;

    // Half of the fraction division: F_HALF bits against one sector
    function automatic t_fdiv f_steps(input t_fdiv x);
        t_fdiv           y;
        logic [SECT_W:0] rem2;
        y = x;
        for (int j = 0; j < F_HALF; j++) begin
            rem2 = {y.rem, 1'b0};
            if (rem2 >= (SECT_W + 1)'(SECT)) begin
                y.rem = SECT_W'(rem2 - (SECT_W + 1)'(SECT));
                y.fq  = {y.fq[FQ_W-2:0], 1'b1};
            end else begin
                y.rem = rem2[SECT_W-1:0];
                y.fq  = {y.fq[FQ_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    function automatic logic [7:0] clamp_byte(input logic signed [C_W-1:0] x);
        if (x < 0) return 8'd0;
        if (x > 16'sd255) return 8'd255;
        return x[7:0];
    endfunction

    // ---- stage 1: offsets
    logic signed [H_W-1:0] h0, n1_h;
    logic signed [S_W-1:0] s0, n1_s;
    logic signed [V_W-1:0] n1_v;
    logic                  r1_pass;
    logic [7:0]            r1_red, r1_green, r1_blue;
    logic signed [H_W-1:0] r1_h;
    logic signed [S_W-1:0] r1_s;
    logic signed [V_W-1:0] r1_v;

    always_comb begin
        if (i_side.black) begin
            h0 = H_W'(-HONE);
        end else if (i_side.gray) begin
            h0 = H_W'(0);
        end else if (i_side.hneg && i_hq != '0) begin
            h0 = H_W'(H360) - H_W'(i_hq);
        end else begin
            h0 = H_W'(i_hq);
        end
        n1_h = h0 + (H_W'(i_shifts.hue) <<< HF);
        s0   = (i_side.black || i_side.gray) ? S_W'(0) : S_W'(i_sq);
        n1_s = s0 + (S_W'(i_shifts.sat) <<< SAT_FRAC);
        n1_v = V_W'(i_side.mx) + V_W'(i_shifts.value);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pass  <= i_side.pass;
            r1_red   <= i_side.red;
            r1_green <= i_side.green;
            r1_blue  <= i_side.blue;
            r1_h     <= n1_h;
            r1_s     <= n1_s;
            r1_v     <= n1_v;
        end
    end

    // ---- stage 2: sector number and remainder
    logic [HMAG_W-1:0]     hmag, cmp;
    logic [3:0]            n2_imag;
    logic                  r2_pass, r2_hsign, r2_szero;
    logic [7:0]            r2_red, r2_green, r2_blue;
    logic [3:0]            r2_imag;
    logic [SECT_W-1:0]     r2_rem;
    logic signed [S_W-1:0] r2_s;
    logic signed [V_W-1:0] r2_v;

    always_comb begin
        hmag = HMAG_W'(r1_h[H_W-1] ? -r1_h : r1_h);
        for (int k = 3; k >= 0; k--) begin
            cmp = HMAG_W'(SECT * (2 ** k));
            n2_imag[k] = (hmag >= cmp);
            if (hmag >= cmp) hmag = hmag - cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pass  <= r1_pass;
            r2_red   <= r1_red;
            r2_green <= r1_green;
            r2_blue  <= r1_blue;
            r2_hsign <= r1_h[H_W-1];
            r2_imag  <= n2_imag;
            r2_rem   <= SECT_W'(hmag);
            r2_s     <= r1_s;
            r2_v     <= r1_v;
            r2_szero <= (r1_s == S_W'(0));
        end
    end

    // ---- stages 3 and 4: fraction within the sector, Q.12
    t_fdiv                 f3_in, r3_fd, r4_fd;
    logic                  r3_pass, r3_hsign, r3_szero;
    logic [7:0]            r3_red, r3_green, r3_blue;
    logic [3:0]            r3_imag;
    logic signed [S_W-1:0] r3_s;
    logic signed [V_W-1:0] r3_v;
    logic                  r4_pass, r4_hsign, r4_szero;
    logic [7:0]            r4_red, r4_green, r4_blue;
    logic [3:0]            r4_imag;
    logic signed [S_W-1:0] r4_s;
    logic signed [V_W-1:0] r4_v;

    assign f3_in.rem = r2_rem;
    assign f3_in.fq  = '0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_fd    <= f_steps(f3_in);
            r3_pass  <= r2_pass;
            r3_red   <= r2_red;
            r3_green <= r2_green;
            r3_blue  <= r2_blue;
            r3_hsign <= r2_hsign;
            r3_imag  <= r2_imag;
            r3_s     <= r2_s;
            r3_v     <= r2_v;
            r3_szero <= r2_szero;

            r4_fd    <= f_steps(r3_fd);
            r4_pass  <= r3_pass;
            r4_red   <= r3_red;
            r4_green <= r3_green;
            r4_blue  <= r3_blue;
            r4_hsign <= r3_hsign;
            r4_imag  <= r3_imag;
            r4_s     <= r3_s;
            r4_v     <= r3_v;
            r4_szero <= r3_szero;
        end
    end

    // ---- stage 5: first products and sector select
    logic signed [F_W-1:0]   f;
    logic signed [OMF_W-1:0] omf;
    logic signed [PT_W-1:0]  pterm;
    t_sector                 n5_sel;
    logic                    r5_pass, r5_szero;
    logic [7:0]              r5_red, r5_green, r5_blue;
    t_sector                 r5_sel;
    logic signed [V_W-1:0]   r5_v;
    logic signed [SF_W-1:0]  r5_sf;
    logic signed [ST_W-1:0]  r5_st;
    logic signed [PP_W-1:0]  r5_pp;

    always_comb begin
        f     = r4_hsign ? -F_W'(r4_fd.fq) : F_W'(r4_fd.fq);
        omf   = OMF_W'(SAT_ONE) - OMF_W'(f);
        pterm = PT_W'(SAT_ONE) - r4_s;
        // negative sectors other than zero take the default case
        if (r4_hsign && r4_imag != 4'd0) begin
            n5_sel = SEC_DEF;
        end else begin
            unique case (r4_imag)
                4'd0:    n5_sel = SEC_0;
                4'd1:    n5_sel = SEC_1;
                4'd2:    n5_sel = SEC_2;
                4'd3:    n5_sel = SEC_3;
                4'd4:    n5_sel = SEC_4;
                default: n5_sel = SEC_DEF;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_pass  <= r4_pass;
            r5_red   <= r4_red;
            r5_green <= r4_green;
            r5_blue  <= r4_blue;
            r5_szero <= r4_szero;
            r5_sel   <= n5_sel;
            r5_v     <= r4_v;
            r5_sf    <= SF_W'(r4_s) * SF_W'(f);
            r5_st    <= ST_W'(r4_s) * ST_W'(omf);
            r5_pp    <= PP_W'(r4_v) * PP_W'(pterm);
        end
    end

    // ---- stage 6: value products, p truncated toward zero
    logic signed [QT_W-1:0] qterm, tterm;
    logic signed [PP_W-1:0] padj;
    logic                   r6_pass, r6_szero;
    logic [7:0]             r6_red, r6_green, r6_blue;
    t_sector                r6_sel;
    logic signed [V_W-1:0]  r6_v;
    logic signed [C_W-1:0]  r6_p;
    logic signed [QP_W-1:0] r6_qp, r6_tp;

    always_comb begin
        qterm = QT_W'(SAT_ONE_SQ) - QT_W'(r5_sf);
        tterm = QT_W'(SAT_ONE_SQ) - QT_W'(r5_st);
        padj  = r5_pp + (r5_pp[PP_W-1] ? PP_W'(SAT_ONE - 1) : PP_W'(0));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_pass  <= r5_pass;
            r6_red   <= r5_red;
            r6_green <= r5_green;
            r6_blue  <= r5_blue;
            r6_szero <= r5_szero;
            r6_sel   <= r5_sel;
            r6_v     <= r5_v;
            r6_p     <= C_W'(padj >>> SAT_FRAC);
            r6_qp    <= QP_W'(r5_v) * QP_W'(qterm);
            r6_tp    <= QP_W'(r5_v) * QP_W'(tterm);
        end
    end

    // ---- stage 7: truncate q and t, select, clamp
    logic signed [QP_W-1:0] qadj, tadj;
    logic signed [C_W-1:0]  q, t, v, ro, go, bo;
    logic [7:0]             n7_red, n7_green, n7_blue;
    logic [7:0]             r7_red, r7_green, r7_blue;

    always_comb begin
        qadj = r6_qp + (r6_qp[QP_W-1] ? QP_W'(SAT_ONE_SQ - 1) : QP_W'(0));
        tadj = r6_tp + (r6_tp[QP_W-1] ? QP_W'(SAT_ONE_SQ - 1) : QP_W'(0));
        q    = C_W'(qadj >>> SAT_SQ_SH);
        t    = C_W'(tadj >>> SAT_SQ_SH);
        v    = C_W'(r6_v);
        unique case (r6_sel)
            SEC_0:   begin ro = v;    go = t;    bo = r6_p; end
            SEC_1:   begin ro = q;    go = v;    bo = r6_p; end
            SEC_2:   begin ro = r6_p; go = v;    bo = t;    end
            SEC_3:   begin ro = r6_p; go = q;    bo = v;    end
            SEC_4:   begin ro = t;    go = r6_p; bo = v;    end
            default: begin ro = v;    go = r6_p; bo = q;    end
        endcase
        if (r6_pass) begin
            n7_red   = r6_red;
            n7_green = r6_green;
            n7_blue  = r6_blue;
        end else if (r6_szero) begin
            n7_red   = clamp_byte(v);
            n7_green = clamp_byte(v);
            n7_blue  = clamp_byte(v);
        end else begin
            n7_red   = clamp_byte(ro);
            n7_green = clamp_byte(go);
            n7_blue  = clamp_byte(bo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_red   <= n7_red;
            r7_green <= n7_green;
            r7_blue  <= n7_blue;
        end
    end

    assign o_red_out   = r7_red;
    assign o_green_out = r7_green;
    assign o_blue_out  = r7_blue;

endmodule

// ===== src/phsv_check.sv =====
// Port-level checker for the palette HSV adjust block, bound to the top level.
// Depends on palette_hsv_adjust_top.
`timescale 1ns / 1ps

module phsv_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out
);

    // Input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A held result always backs up the input
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while a result is held");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result shown right after reset");

    // Held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_red_out) &&
                                  $stable(o_green_out) && $stable(o_blue_out)))
        else $error("stalled result changed");

endmodule

bind palette_hsv_adjust_top phsv_check u_check (.*);
